>>> rtl/salru_pkg.sv
// Shared constants, codes and types for the set-associative LRU write-back cache directory.
`timescale 1ns / 1ps
`default_nettype none
package salru_pkg;

   localparam int SET_IN_W = 8;
   localparam int TAG_IN_W = 24;
   localparam int WAY_OUT_W = 3;
   localparam int CSR_W = 4;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;
   localparam int OUTCOME_W = 2;

   localparam logic [CSR_W-1:0] WAYS_RESET = 4'd8;

   localparam logic [OUTCOME_W-1:0] OUTCOME_HIT = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_FILL = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_EVICT = 2'd2;

   typedef struct packed {
      logic [OUTCOME_W-1:0] outcome;
      logic [WAY_OUT_W-1:0] way_used;
      logic                 write_back;
      logic [TAG_IN_W-1:0]  victim_tag;
   } rsp_type;

endpackage
`default_nettype wire

>>> rtl/salru_dir_ram.sv
// Synchronous single-port-write, single-port-read directory memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module salru_dir_ram #(
   parameter int DEPTH = 256,
   parameter int ADDR_W = 8,
   parameter int DATA_W = 256
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/salru_lookup.sv
// Set lookup and update: tag match, fill or LRU victim choice, rank aging and new set contents.
`timescale 1ns / 1ps
`default_nettype none
module salru_lookup #(
   parameter int MAX_WAYS = 8,
   parameter int TAG_BITS = 24,
   parameter int WAY_W = 3,
   parameter int CNT_W = 4
) (
   input  wire logic [CNT_W-1:0]    active_n,
   input  wire logic                is_write,
   input  wire logic [TAG_BITS-1:0] req_tag,
   input  wire logic [TAG_BITS-1:0] cur_tag   [MAX_WAYS],
   input  wire logic                cur_valid [MAX_WAYS],
   input  wire logic                cur_dirty [MAX_WAYS],
   input  wire logic [WAY_W-1:0]    cur_rank  [MAX_WAYS],
   output logic      [TAG_BITS-1:0] new_tag   [MAX_WAYS],
   output logic                     new_valid [MAX_WAYS],
   output logic                     new_dirty [MAX_WAYS],
   output logic      [WAY_W-1:0]    new_rank  [MAX_WAYS],
   output salru_pkg::rsp_type       result
);

   logic             active [MAX_WAYS];
   logic             hit;
   logic             empty;
   logic [WAY_W-1:0] hit_way;
   logic [WAY_W-1:0] empty_way;
   logic [WAY_W-1:0] lru_way;
   logic [WAY_W-1:0] lru_rank;
   logic [WAY_W-1:0] way;
   logic [WAY_W-1:0] way_rank;
   logic [31:0]      way32;
   logic [31:0]      victim32;

   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         active[w] = CNT_W'(w) < active_n;
      end
   end

   always_comb begin
      hit = 1'b0;
      hit_way = '0;
      empty = 1'b0;
      empty_way = '0;
      lru_way = '0;
      lru_rank = cur_rank[0];
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (!hit && active[w] && cur_valid[w] && (cur_tag[w] == req_tag)) begin
            hit = 1'b1;
            hit_way = WAY_W'(w);
         end
         if (!empty && active[w] && !cur_valid[w]) begin
            empty = 1'b1;
            empty_way = WAY_W'(w);
         end
         if (active[w] && (cur_rank[w] > lru_rank)) begin
            lru_rank = cur_rank[w];
            lru_way = WAY_W'(w);
         end
      end
   end

   always_comb begin
      if (hit) begin
         way = hit_way;
      end else if (empty) begin
         way = empty_way;
      end else begin
         way = lru_way;
      end
      way_rank = cur_rank[way];
   end

   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         new_tag[w] = cur_tag[w];
         new_valid[w] = cur_valid[w];
         new_dirty[w] = cur_dirty[w];
         if (active[w] && (cur_rank[w] < way_rank)) begin
            new_rank[w] = cur_rank[w] + WAY_W'(1);
         end else begin
            new_rank[w] = cur_rank[w];
         end
      end
      new_rank[way] = '0;
      if (hit) begin
         if (is_write) begin
            new_dirty[way] = 1'b1;
         end
      end else begin
         new_tag[way] = req_tag;
         new_valid[way] = 1'b1;
         new_dirty[way] = is_write;
      end
   end

   assign way32 = 32'(way);
   assign victim32 = 32'(cur_tag[lru_way]);

   always_comb begin
      result.way_used = way32[salru_pkg::WAY_OUT_W-1:0];
      result.write_back = 1'b0;
      result.victim_tag = '0;
      if (hit) begin
         result.outcome = salru_pkg::OUTCOME_HIT;
      end else if (empty) begin
         result.outcome = salru_pkg::OUTCOME_FILL;
      end else begin
         result.outcome = salru_pkg::OUTCOME_EVICT;
         result.write_back = cur_dirty[lru_way];
         result.victim_tag = victim32[salru_pkg::TAG_IN_W-1:0];
      end
   end

endmodule
`default_nettype wire

>>> rtl/set_assoc_lru_writeback_cache_top.sv
// Top level of the set-associative LRU write-back cache directory.
//
//  Channel | Ports                    | Direction | Contents
//  --------+--------------------------+-----------+-----------------------------------------
//  request | req_tvalid/tready/tdata  | in        | tdata: set_index, tag; tuser: req_type
//  result  | rsp_tvalid/tready/tdata  | out       | tdata: way_used, write_back, victim_tag;
//          |                          |           | tuser: outcome
//  config  | csr_valid/ready/data     | in        | ways_in_use
//
// For each item its set row is first read from the directory memory, then the row is
// updated and written back; no new item is accepted until that write-back is done.
// After reset a clearing pass writes every set row, with no item accepted.
// A result waits in an output register; the update stalls while that register holds an item
// that the receiver does not take.
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_lru_writeback_cache_top #(
   parameter int NUM_SETS = 256,
   parameter int MAX_WAYS = 8,
   parameter int TAG_BITS = 24
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // set_index[7:0], tag[31:8]
   input  wire logic        req_tuser,  // req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,  // way_used[2:0], write_back[3], victim_tag[27:4], zero
   output logic      [1:0]  rsp_tuser,  // outcome
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_data    // ways_in_use
);

   localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int CNT_W = $clog2(MAX_WAYS + 1);
   localparam int ENT_W = TAG_BITS + 2 + WAY_W;
   localparam int ROW_W = MAX_WAYS * ENT_W;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE = 2'd1;
   localparam logic [1:0] ST_LOOKUP = 2'd2;

   function automatic logic [SET_W-1:0] set_reduce(input logic [salru_pkg::SET_IN_W-1:0] v);
      logic [24:0] x;
      logic [24:0] m;
      x = 25'(v);
      for (int k = 7; k >= 0; k--) begin
         m = 25'(NUM_SETS) << k;
         if (x >= m) begin
            x = x - m;
         end
      end
      return SET_W'(x);
   endfunction

   logic [1:0]                     state_ff, state_in;
   logic [SET_W-1:0]               clr_idx_ff, clr_idx_in;
   logic [salru_pkg::CSR_W-1:0]    ways_ff, ways_in;
   logic [SET_W-1:0]               set_ff, set_in;
   logic [TAG_BITS-1:0]            tag_ff, tag_in;
   logic                           write_ff, write_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   salru_pkg::rsp_type             rsp_ff, rsp_in;

   logic                           req_acc;
   logic                           update;
   logic [4:0]                     ways_wide;
   logic [CNT_W-1:0]               active_n;
   logic [31:0]                    tag_wide;

   logic                           ram_we;
   logic [SET_W-1:0]               ram_waddr;
   logic [ROW_W-1:0]               ram_wdata;
   logic [ROW_W-1:0]               ram_rdata;
   logic [ROW_W-1:0]               upd_row;
   logic [ROW_W-1:0]               clr_row;

   logic [TAG_BITS-1:0]            cur_tag   [MAX_WAYS];
   logic                           cur_valid [MAX_WAYS];
   logic                           cur_dirty [MAX_WAYS];
   logic [WAY_W-1:0]               cur_rank  [MAX_WAYS];
   logic [TAG_BITS-1:0]            new_tag   [MAX_WAYS];
   logic                           new_valid [MAX_WAYS];
   logic                           new_dirty [MAX_WAYS];
   logic [WAY_W-1:0]               new_rank  [MAX_WAYS];
   salru_pkg::rsp_type             result;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc = req_tvalid && req_tready;
   assign update = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || rsp_tready);
   assign csr_ready = 1'b1;
   assign tag_wide = 32'(req_tdata[31:8]);

   always_comb begin
      ways_wide = {1'b0, ways_ff};
      if (ways_wide == 5'd0) begin
         ways_wide = 5'd1;
      end else if (ways_wide > 5'(MAX_WAYS)) begin
         ways_wide = 5'(MAX_WAYS);
      end
      active_n = CNT_W'(ways_wide);
   end

   generate
      for (genvar w = 0; w < MAX_WAYS; w++) begin : g_way
         assign cur_tag[w] = ram_rdata[w*ENT_W +: TAG_BITS];
         assign cur_valid[w] = ram_rdata[w*ENT_W + TAG_BITS];
         assign cur_dirty[w] = ram_rdata[w*ENT_W + TAG_BITS + 1];
         assign cur_rank[w] = ram_rdata[w*ENT_W + TAG_BITS + 2 +: WAY_W];
         assign upd_row[w*ENT_W +: ENT_W] = {new_rank[w], new_dirty[w], new_valid[w], new_tag[w]};
         assign clr_row[w*ENT_W +: ENT_W] = {WAY_W'(w), 1'b0, 1'b0, {TAG_BITS{1'b0}}};
      end
   endgenerate

   salru_lookup #(
      .MAX_WAYS(MAX_WAYS),
      .TAG_BITS(TAG_BITS),
      .WAY_W(WAY_W),
      .CNT_W(CNT_W)
   ) u_lookup (
      .active_n (active_n),
      .is_write (write_ff),
      .req_tag  (tag_ff),
      .cur_tag  (cur_tag),
      .cur_valid(cur_valid),
      .cur_dirty(cur_dirty),
      .cur_rank (cur_rank),
      .new_tag  (new_tag),
      .new_valid(new_valid),
      .new_dirty(new_dirty),
      .new_rank (new_rank),
      .result   (result)
   );

   always_comb begin
      ram_we = 1'b0;
      ram_waddr = set_ff;
      ram_wdata = upd_row;
      if (state_ff == ST_CLEAR) begin
         ram_we = 1'b1;
         ram_waddr = clr_idx_ff;
         ram_wdata = clr_row;
      end else if (update) begin
         ram_we = 1'b1;
      end
   end

   salru_dir_ram #(
      .DEPTH(NUM_SETS),
      .ADDR_W(SET_W),
      .DATA_W(ROW_W)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (req_acc),
      .rd_addr(set_in),
      .rd_data(ram_rdata)
   );

   always_comb begin
      state_in = state_ff;
      clr_idx_in = clr_idx_ff;
      ways_in = ways_ff;
      set_in = set_reduce(req_tdata[7:0]);
      tag_in = tag_ff;
      write_in = write_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (csr_valid && csr_ready) begin
         ways_in = csr_data;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_CLEAR: begin
            clr_idx_in = clr_idx_ff + SET_W'(1);
            if (clr_idx_ff == SET_W'(NUM_SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               tag_in = TAG_BITS'(tag_wide);
               write_in = req_tuser;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (update) begin
               rsp_in = result;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_idx_ff <= '0;
         ways_ff <= salru_pkg::WAYS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_idx_ff <= clr_idx_in;
         ways_ff <= ways_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         set_ff <= set_in;
      end
      tag_ff <= tag_in;
      write_ff <= write_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_ff.outcome;
   assign rsp_tdata = {4'd0, rsp_ff.victim_tag, rsp_ff.write_back, rsp_ff.way_used};

endmodule
`default_nettype wire

>>> rtl/salru_checker.sv
// Port-level checks for the cache directory top level, bound to every instance.
`timescale 1ns / 1ps
`default_nettype none
module salru_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   a_item_spacing: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("Request ready did not drop after an accepted item.");

   a_wb_only_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[3]) |-> (rsp_tuser == salru_pkg::OUTCOME_EVICT))
      else $error("Write-back reported without an eviction.");

   a_victim_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != salru_pkg::OUTCOME_EVICT)) |-> (rsp_tdata[27:4] == 24'd0))
      else $error("Victim tag is nonzero on a hit or fill.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("Result item changed while stalled.");

endmodule

bind set_assoc_lru_writeback_cache_top salru_checker u_salru_checker (.*);
`default_nettype wire

>>> bench/tb_set_assoc_lru_writeback_cache_top.sv
// Self-checking testbench for the set-associative LRU write-back cache directory.
`timescale 1ns / 1ps
module tb_set_assoc_lru_writeback_cache_top;

   localparam int SETS = 256;
   localparam int WAYS = 8;
   localparam int PHASES = 9;
   localparam int PHASE_ITEMS = 38;
   localparam bit [salru_pkg::CSR_W-1:0] PHASE_WAYS [PHASES] =
      '{4'd1, 4'd0, 4'd15, 4'd3, 4'd9, 4'd2, 4'd8, 4'd5, 4'd8};

   typedef enum bit {REQ_READ = 1'b0, REQ_WRITE = 1'b1} req_kind_type;

   typedef struct packed {
      req_kind_type                     kind;
      logic [salru_pkg::SET_IN_W-1:0]   set_index;
      logic [salru_pkg::TAG_IN_W-1:0]   tag;
   } cache_req_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [salru_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                             req_tuser = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [salru_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [salru_pkg::OUTCOME_W-1:0]  rsp_tuser;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [salru_pkg::CSR_W-1:0]      csr_data = '0;

   // Shadow copy of the directory and of the ways register.
   logic [salru_pkg::TAG_IN_W-1:0] line_tag [SETS][WAYS];
   bit                             line_valid [SETS][WAYS];
   bit                             line_dirty [SETS][WAYS];
   bit [2:0]                       line_age [SETS][WAYS];
   logic [salru_pkg::CSR_W-1:0]    ways_cfg = salru_pkg::WAYS_RESET;

   cache_req_type                  access_queue[$];
   salru_pkg::rsp_type             predicted_lookups[$];
   cache_req_type                  offered_req;
   logic [salru_pkg::SET_IN_W-1:0] hot_sets [4];
   logic [salru_pkg::TAG_IN_W-1:0] hot_tags [12];
   int                             send_gap = 0;
   int                             stall_left = 0;
   int                             hold_left = 0;
   bit                             hold_done = 1'b0;
   bit                             calm = 1'b0;
   int                             results_seen = 0;
   int                             mismatches = 0;

   set_assoc_lru_writeback_cache_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic salru_pkg::rsp_type cache_lookup(cache_req_type r);
      salru_pkg::rsp_type res;
      int unsigned        n, w, way;
      bit                 found;
      bit [2:0]           age;
      n = (ways_cfg == '0) ? 1 : ((ways_cfg > WAYS) ? WAYS : ways_cfg);
      res = '0;
      way = 0;
      found = 1'b0;
      for (w = 0; w < n; w++) begin
         if (!found && line_valid[r.set_index][w] && line_tag[r.set_index][w] == r.tag) begin
            way = w;
            found = 1'b1;
         end
      end
      if (found) begin
         res.outcome = salru_pkg::OUTCOME_HIT;
         if (r.kind == REQ_WRITE) line_dirty[r.set_index][way] = 1'b1;
      end else begin
         for (w = 0; w < n; w++) begin
            if (!found && !line_valid[r.set_index][w]) begin
               way = w;
               found = 1'b1;
            end
         end
         if (found) begin
            res.outcome = salru_pkg::OUTCOME_FILL;
         end else begin
            way = 0;
            for (w = 1; w < n; w++) begin
               if (line_age[r.set_index][w] > line_age[r.set_index][way]) way = w;
            end
            res.outcome = salru_pkg::OUTCOME_EVICT;
            res.write_back = line_dirty[r.set_index][way];
            res.victim_tag = line_tag[r.set_index][way];
         end
         line_tag[r.set_index][way] = r.tag;
         line_valid[r.set_index][way] = 1'b1;
         line_dirty[r.set_index][way] = (r.kind == REQ_WRITE);
      end
      age = line_age[r.set_index][way];
      for (w = 0; w < n; w++) begin
         if (line_age[r.set_index][w] < age) line_age[r.set_index][w]++;
      end
      line_age[r.set_index][way] = 3'd0;
      res.way_used = way[salru_pkg::WAY_OUT_W-1:0];
      return res;
   endfunction

   function automatic void queue_access(req_kind_type k, logic [salru_pkg::SET_IN_W-1:0] s,
                                        logic [salru_pkg::TAG_IN_W-1:0] t);
      cache_req_type r;
      r.kind = k;
      r.set_index = s;
      r.tag = t;
      access_queue.push_back(r);
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (access_queue.size() != 0 || req_tvalid || predicted_lookups.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_ways(input logic [salru_pkg::CSR_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock);
      while (!csr_ready);
      ways_cfg = value;
      csr_valid <= 1'b0;
   endtask

   task automatic queue_random_accesses(input int count);
      int                             i;
      logic [salru_pkg::SET_IN_W-1:0] s;
      logic [salru_pkg::TAG_IN_W-1:0] t;
      for (i = 0; i < 3; i++) hot_tags[$urandom_range(2, 11)] = 24'($urandom);
      for (i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 85) begin
            s = hot_sets[$urandom_range(0, 3)];
            t = hot_tags[$urandom_range(0, 11)];
         end else begin
            s = 8'($urandom_range(0, SETS - 1));
            t = 24'($urandom);
         end
         queue_access(req_kind_type'($urandom_range(0, 1)), s, t);
      end
   endtask

   // Request driver.
   always @(posedge clock) begin
      logic nxt_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         nxt_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            predicted_lookups.push_back(cache_lookup(offered_req));
            nxt_valid = 1'b0;
         end
         if (!nxt_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (access_queue.size() > 0) begin
               if (!calm && $urandom_range(0, 3) == 0) begin
                  send_gap = $urandom_range(1, 7) - 1;
               end else begin
                  offered_req = access_queue.pop_front();
                  req_tdata <= {offered_req.tag, offered_req.set_index};
                  req_tuser <= offered_req.kind;
                  nxt_valid = 1'b1;
               end
            end
         end
         req_tvalid <= nxt_valid;
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      salru_pkg::rsp_type want;
      logic               nxt_ready;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_lookups.size() == 0) begin
               report_mismatch($sformatf("result with none expected: outcome %0d tdata %h",
                                         rsp_tuser, rsp_tdata));
            end else begin
               want = predicted_lookups.pop_front();
               if (rsp_tuser !== want.outcome || rsp_tdata[2:0] !== want.way_used ||
                   rsp_tdata[3] !== want.write_back || rsp_tdata[27:4] !== want.victim_tag)
                  report_mismatch($sformatf(
                     "result %0d: outcome %0d way %0d wb %0d victim %h, expected %0d %0d %0d %h",
                     results_seen, rsp_tuser, rsp_tdata[2:0], rsp_tdata[3], rsp_tdata[27:4],
                     want.outcome, want.way_used, want.write_back, want.victim_tag));
            end
            results_seen++;
         end
         nxt_ready = 1'b1;
         if (!hold_done && results_seen == 40) begin
            hold_left = 250;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            nxt_ready = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            nxt_ready = 1'b0;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            nxt_ready = 1'b0;
         end
         rsp_tready <= nxt_ready;
      end
   end

   initial begin
      int                          s, w, p;
      logic [salru_pkg::CSR_W-1:0] ways_value;
      for (s = 0; s < SETS; s++) begin
         for (w = 0; w < WAYS; w++) begin
            line_tag[s][w] = '0;
            line_valid[s][w] = 1'b0;
            line_dirty[s][w] = 1'b0;
            line_age[s][w] = w[2:0];
         end
      end
      hot_sets[0] = 8'd0;
      hot_sets[1] = 8'd255;
      hot_sets[2] = 8'($urandom_range(1, 254));
      hot_sets[3] = 8'($urandom_range(1, 254));
      hot_tags[0] = 24'h000000;
      hot_tags[1] = 24'hFFFFFF;
      for (s = 2; s < 12; s++) hot_tags[s] = 24'($urandom);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Fills, hits, a dirty and a clean eviction, both corner sets and tags.
      queue_access(REQ_READ, 8'd0, 24'h000000);
      queue_access(REQ_WRITE, 8'd0, 24'h000000);
      queue_access(REQ_READ, 8'd255, 24'hFFFFFF);
      queue_access(REQ_WRITE, 8'd255, 24'hFFFFFF);
      for (w = 1; w < WAYS; w++)
         queue_access((w % 2) ? REQ_READ : REQ_WRITE, 8'd0, 24'(w));
      queue_access(REQ_READ, 8'd0, 24'h000000);
      queue_access(REQ_READ, 8'd0, 24'h800000);
      queue_access(REQ_WRITE, 8'd0, 24'hABCDEF);
      queue_access(REQ_READ, 8'd0, 24'h800000);
      queue_access(REQ_WRITE, 8'd0, 24'h000001);
      queue_access(REQ_READ, 8'd0, 24'h000000);
      queue_access(REQ_READ, 8'd255, 24'h7FFFFF);
      queue_random_accesses(PHASE_ITEMS);
      wait_idle();

      for (p = 0; p < PHASES; p++) begin
         ways_value = (p == 7) ? 4'($urandom_range(0, 15)) : PHASE_WAYS[p];
         write_ways(ways_value);
         if (p == PHASES - 1) calm = 1'b1;
         queue_random_accesses(PHASE_ITEMS);
         wait_idle();
      end

      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

>>> files.f
rtl/salru_pkg.sv
rtl/salru_dir_ram.sv
rtl/salru_lookup.sv
rtl/set_assoc_lru_writeback_cache_top.sv
rtl/salru_checker.sv
bench/tb_set_assoc_lru_writeback_cache_top.sv
